>>> design/ntf_pkg.sv
// Shared constants, codes and controller/datapath interface types for the triangle fan block.
package ntf_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int COUNT_W      = ADDR_W + 1;
  localparam int COORD_BITS   = 16;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int SQ_W         = 2 * COORD_BITS;
  localparam int DIST_W       = SQ_W + 2;
  localparam int IDX_W        = 10;
  localparam int FUNC_W       = 2;
  localparam int NEIGHBOURS   = 3;
  localparam int KEPT_W       = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR    = 2'd0,
    FUNC_APPEND   = 2'd1,
    FUNC_GENERATE = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT_RD,
    ST_ROOT_CAP,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic start;
    logic rd_root;
    logic root_cap;
    logic scan_step;
    logic emit_adv;
  } ntf_cmd_t;

  typedef struct packed {
    logic gen_ok;
    logic scan_last;
    logic pipe_busy;
    logic emit_last;
  } ntf_stat_t;

endpackage

>>> design/ntf_datapath.sv
// Datapath: vertex memory, distance pipeline, three-entry nearest list and triangle output.
module ntf_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ntf_pkg::ntf_cmd_t                    cmd,
  output ntf_pkg::ntf_stat_t                   stat,
  input  logic signed [ntf_pkg::COORD_BITS-1:0] pos_x,
  input  logic signed [ntf_pkg::COORD_BITS-1:0] pos_y,
  input  logic signed [ntf_pkg::COORD_BITS-1:0] pos_z,
  input  logic        [ntf_pkg::IDX_W-1:0]      query_index,
  output logic        [ntf_pkg::IDX_W-1:0]      root_index,
  output logic        [ntf_pkg::IDX_W-1:0]      near_index,
  output logic        [ntf_pkg::IDX_W-1:0]      next_index,
  output logic                                 last
);
  import ntf_pkg::*;

  localparam int VW = 3 * COORD_BITS;

  logic [VW-1:0]          mem [MAX_VERTICES];
  logic [VW-1:0]          rd_data;
  logic [ADDR_W-1:0]      rd_addr;
  logic [COUNT_W-1:0]     count;
  logic [COUNT_W-1:0]     count_m1;
  logic                   full;
  logic [ADDR_W-1:0]      root;
  logic [ADDR_W-1:0]      scan_idx;
  logic [COORD_BITS-1:0]  root_x, root_y, root_z;

  // pipeline: 1 = memory data, 2 = differences, 3 = squares, 4 = sum
  logic                   v1, v2, v3, v4;
  logic [ADDR_W-1:0]      i1, i2, i3, i4;
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic [SQ_W-1:0]        sqx, sqy, sqz;
  logic [DIST_W-1:0]      sum_sq;
  logic signed [2*DIFF_W-1:0] px, py, pz;
  logic [COORD_BITS-1:0]  rx, ry, rz;

  logic [DIST_W-1:0]      best_dist [NEIGHBOURS];
  logic [ADDR_W-1:0]      best_idx  [NEIGHBOURS];
  logic [KEPT_W-1:0]      kept;
  logic [KEPT_W-1:0]      kept_m1;
  logic                   lt0, lt1, lt2;
  logic [KEPT_W-1:0]      emit_k;
  logic [KEPT_W-1:0]      next_k;

  assign full     = (count == COUNT_W'(MAX_VERTICES));
  assign count_m1 = count - COUNT_W'(1);
  assign rd_addr  = cmd.rd_root ? root : scan_idx;
  assign {rx, ry, rz} = rd_data;

  // vertex memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      mem[count[ADDR_W-1:0]] <= {pos_x, pos_y, pos_z};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.append && !full) begin
      count <= count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      root <= ADDR_W'(query_index);
    end
    if (cmd.root_cap) begin
      root_x <= rx;
      root_y <= ry;
      root_z <= rz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (cmd.start) begin
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + ADDR_W'(1);
    end
  end

  // distance pipeline valid bits; the root itself is never sent down
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.scan_step && (scan_idx != root);
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  always_ff @(posedge clk) begin
    i1  <= scan_idx;
    i2  <= i1;
    i3  <= i2;
    i4  <= i3;
    dx  <= $signed({rx[COORD_BITS-1], rx}) - $signed({root_x[COORD_BITS-1], root_x});
    dy  <= $signed({ry[COORD_BITS-1], ry}) - $signed({root_y[COORD_BITS-1], root_y});
    dz  <= $signed({rz[COORD_BITS-1], rz}) - $signed({root_z[COORD_BITS-1], root_z});
    sqx <= px[SQ_W-1:0];
    sqy <= py[SQ_W-1:0];
    sqz <= pz[SQ_W-1:0];
    sum_sq <= DIST_W'(sqx) + DIST_W'(sqy) + DIST_W'(sqz);
  end

  // sorted insertion; strict less keeps the earlier index on a tie
  assign lt0 = (kept == KEPT_W'(0)) || (sum_sq < best_dist[0]);
  assign lt1 = (kept <  KEPT_W'(2)) || (sum_sq < best_dist[1]);
  assign lt2 = (kept <  KEPT_W'(NEIGHBOURS)) || (sum_sq < best_dist[2]);

  always_ff @(posedge clk) begin
    if (v4) begin
      priority if (lt0) begin
        best_dist[2] <= best_dist[1];
        best_idx[2]  <= best_idx[1];
        best_dist[1] <= best_dist[0];
        best_idx[1]  <= best_idx[0];
        best_dist[0] <= sum_sq;
        best_idx[0]  <= i4;
      end else if (lt1) begin
        best_dist[2] <= best_dist[1];
        best_idx[2]  <= best_idx[1];
        best_dist[1] <= sum_sq;
        best_idx[1]  <= i4;
      end else if (lt2) begin
        best_dist[2] <= sum_sq;
        best_idx[2]  <= i4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept <= '0;
    end else if (cmd.start) begin
      kept <= '0;
    end else if (v4 && kept != KEPT_W'(NEIGHBOURS)) begin
      kept <= kept + KEPT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_k <= '0;
    end else if (cmd.start) begin
      emit_k <= '0;
    end else if (cmd.emit_adv) begin
      emit_k <= emit_k + KEPT_W'(1);
    end
  end

  assign kept_m1 = kept - KEPT_W'(1);
  assign next_k  = (emit_k == kept_m1) ? KEPT_W'(0) : emit_k + KEPT_W'(1);

  assign root_index = IDX_W'(root);
  assign near_index = IDX_W'(best_idx[emit_k]);
  assign next_index = IDX_W'(best_idx[next_k]);
  assign last       = (emit_k == kept_m1);

  assign stat.gen_ok    = (count >= COUNT_W'(NEIGHBOURS)) && (COUNT_W'(query_index) < count);
  assign stat.scan_last = ({1'b0, scan_idx} == count_m1);
  assign stat.pipe_busy = v1 | v2 | v3 | v4;
  assign stat.emit_last = (emit_k == kept_m1);

endmodule

>>> design/ntf_ctrl.sv
// Controller: sequences store updates, the neighbor scan and triangle output.
module ntf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ntf_pkg::FUNC_W-1:0] func,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  ntf_pkg::ntf_stat_t    stat,
  output ntf_pkg::ntf_cmd_t     cmd,
  output ntf_pkg::state_t       state
);
  import ntf_pkg::*;

  state_t state_next;
  logic   in_acc;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (func == FUNC_CLEAR) begin
            cmd.clear = 1'b1;
          end
          if (func == FUNC_APPEND) begin
            cmd.append = 1'b1;
          end
          if (func == FUNC_GENERATE && stat.gen_ok) begin
            cmd.start  = 1'b1;
            state_next = ST_ROOT_RD;
          end
        end
      end
      ST_ROOT_RD: begin
        cmd.rd_root = 1'b1;
        state_next  = ST_ROOT_CAP;
      end
      ST_ROOT_CAP: begin
        cmd.root_cap = 1'b1;
        state_next   = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          cmd.emit_adv = 1'b1;
          if (stat.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/nearest_three_triangle_fan_top.sv
// Top level of the nearest-three triangle fan generator.
// Holds up to 1024 vertices (signed Q8.8 x, y, z) appended one per transaction;
// a clear transaction empties the store and appends to a full store are dropped.
// A generate transaction names a root vertex: the block scans all stored
// vertices, keeps the three with the smallest squared distance to the root
// (a tie goes to the lower index) and then emits one triangle per kept
// neighbor, (root, neighbor k, neighbor k+1 cyclically), nearest first, with
// last set on the final one. With exactly three stored vertices two triangles
// come out; with fewer than three, or a root index at or past the count,
// nothing comes out.
// Clear, append and an ignored code complete in the idle state. Before the
// first triangle of a generate, the block fetches the root, then reads each
// stored vertex in turn through the single read port of the vertex memory,
// then the four-stage difference/square/sum/insert pipeline drains.
// Triangles then leave at one per cycle while out_ready is high. Input is
// taken only when the block is idle, so one generate transaction is in
// flight at a time.
module nearest_three_triangle_fan_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic        [ntf_pkg::FUNC_W-1:0]     func,
  input  logic signed [ntf_pkg::COORD_BITS-1:0] pos_x,
  input  logic signed [ntf_pkg::COORD_BITS-1:0] pos_y,
  input  logic signed [ntf_pkg::COORD_BITS-1:0] pos_z,
  input  logic        [ntf_pkg::IDX_W-1:0]      query_index,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [ntf_pkg::IDX_W-1:0]      root_index,
  output logic        [ntf_pkg::IDX_W-1:0]      near_index,
  output logic        [ntf_pkg::IDX_W-1:0]      next_index,
  output logic                                  last
);
  import ntf_pkg::*;

  ntf_cmd_t  cmd;
  ntf_stat_t stat;
  state_t    state;

  // controller: owns the handshakes and the sequence of a generate
  ntf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd),
    .state     (state)
  );

  // datapath: memory, distance pipeline, nearest list, triangle fields
  ntf_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .query_index (query_index),
    .root_index  (root_index),
    .near_index  (near_index),
    .next_index  (next_index),
    .last        (last)
  );

`ifndef SYNTH
  // no input transaction while triangles are being delivered
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while output pending");

  // the final triangle returns the block to idle
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> !out_valid && in_ready)
    else $error("output continued past last triangle");

  // output only after the distance pipeline has drained
  a_drained: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !stat.pipe_busy)
    else $error("output while distance pipeline busy");

  // the scan only runs in the scan state
  a_scan_state: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> state == ST_SCAN)
    else $error("scan step outside scan state");
`endif

endmodule
